/* rtl/core/prsw_pkg.sv */
// Shared types and constants for the partial-reliability stop-and-wait sender.
package prsw_pkg;

	localparam int WINDOW_SIZE = 100;
	localparam int PTR_W       = $clog2(WINDOW_SIZE);
	localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
	localparam int TOL_W       = 7;
	localparam int LOSS_W      = 7;
	localparam int PCT_SCALE   = 100;
	localparam int CMP_W       = CNT_W + TOL_W + $clog2(PCT_SCALE + 1) + $clog2(WINDOW_SIZE + 1);
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;
	localparam int LOSS_SAT    = (1 << LOSS_W) - 1;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(5);

	// register index taken from paddr[2]
	localparam logic REG_LOSS_TOL = 1'b0;

	localparam logic OP_SEND  = 1'b0;
	localparam logic OP_REPLY = 1'b1;

	typedef enum logic [1:0] {
		OUT_PENDING   = 2'd0,
		OUT_ACKED     = 2'd1,
		OUT_LOSS_OK   = 2'd2,
		OUT_ORDER_ERR = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FIRST = 2'd1,
		PH_RETRY = 2'd2
	} phase_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		logic             data;
	} win_wr_t;

	typedef struct packed {
		logic              transmit;
		logic              frame_seq;
		logic              frame_ack_flag;
		logic              done_res;
		logic [1:0]        outcome;
		logic [LOSS_W-1:0] losses_in_window;
	} res_t;

endpackage

/* rtl/core/prsw_if.sv */
// Valid/ready channel interfaces for request and result beats.
interface prsw_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic reply_received;
	logic reply_ack_flag;
	logic reply_syn_flag;
	logic reply_ack_number;

	modport source (output valid, operation, reply_received, reply_ack_flag, reply_syn_flag,
		reply_ack_number, input ready);
	modport sink (input valid, operation, reply_received, reply_ack_flag, reply_syn_flag,
		reply_ack_number, output ready);
	modport mon (input valid, ready, operation, reply_received, reply_ack_flag, reply_syn_flag,
		reply_ack_number);
endinterface

interface prsw_out_if;
	logic                        valid;
	logic                        ready;
	logic                        transmit;
	logic                        frame_seq;
	logic                        frame_ack_flag;
	logic                        done_res;
	logic [1:0]                  outcome;
	logic [prsw_pkg::LOSS_W-1:0] losses_in_window;

	modport source (output valid, transmit, frame_seq, frame_ack_flag, done_res, outcome,
		losses_in_window, input ready);
	modport sink (input valid, transmit, frame_seq, frame_ack_flag, done_res, outcome,
		losses_in_window, output ready);
	modport mon (input valid, ready, transmit, frame_seq, frame_ack_flag, done_res, outcome,
		losses_in_window);
endinterface

/* rtl/core/prsw_window.sv */
// Loss window store: one bit per slot, valid bits cleared at reset, registered read.
module prsw_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  prsw_pkg::win_wr_t           wr,
	input  logic [prsw_pkg::PTR_W-1:0]  rd_addr,
	output logic                        rd_bit
);
	import prsw_pkg::*;

	logic                   mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0] vld_q;
	logic                   rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (wr.en && wr.addr == rd_addr) begin
				rd_q <= wr.data;
			end else begin
				rd_q <= vld_q[rd_addr] & mem[rd_addr];
			end
		end
	end

	assign rd_bit = rd_q;

endmodule

/* rtl/core/partial_reliability_stop_and_wait_tx.sv */
// Top level of the partial-reliability stop-and-wait sender.
// Each accepted request beat yields one result beat, held in the output register or the skid.
// Throughput: one request beat per cycle; a two-deep output stage (register plus skid)
// keeps accepting while one result waits, so item ready drops only when both hold beats.
// Reset (arst_n low): idle phase, sequence bit 0, unconnected, window pointer and loss
// count 0, all window slots read as not lost, loss tolerance 5 percent.
module partial_reliability_stop_and_wait_tx (
	input  logic                         clk,
	input  logic                         arst_n,
	prsw_in_if.sink                      item,
	prsw_out_if.source                   result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [prsw_pkg::ADDR_W-1:0]  paddr,
	input  logic [prsw_pkg::DATA_W-1:0]  pwdata,
	output logic [prsw_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import prsw_pkg::*;

	phase_t            phase_q, phase_d;
	logic [PTR_W-1:0]  ptr_q, ptr_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_lost, cnt_clr;
	logic              seq_q, seq_d;
	logic              conn_q, conn_d;
	logic              hack_q, hack_d;
	logic [TOL_W-1:0]  tol_q;
	logic              slot_lost;
	logic              acc;
	logic              valid_ack;
	logic              match;
	logic              over_tol;
	logic [CMP_W-1:0]  loss_scaled;
	logic [CMP_W-1:0]  tol_scaled;
	win_wr_t           wr;
	res_t              res;
	res_t              o_q, s_q;
	logic              o_vld_q, s_vld_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LOSS_TOL) ? DATA_W'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_LOSS_TOL) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	prsw_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (ptr_d),
		.rd_bit  (slot_lost)
	);

	assign acc       = item.valid && item.ready;
	assign valid_ack = item.reply_received && item.reply_ack_flag && !item.reply_syn_flag;
	assign match     = item.reply_ack_number == seq_q;
	assign cnt_lost  = slot_lost ? cnt_q : cnt_q + CNT_W'(1);
	assign cnt_clr   = slot_lost ? cnt_q - CNT_W'(1) : cnt_q;
	assign loss_scaled = CMP_W'(cnt_lost) * CMP_W'(PCT_SCALE);
	assign tol_scaled  = CMP_W'(tol_q) * CMP_W'(WINDOW_SIZE);
	assign over_tol    = loss_scaled > tol_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ptr_q   <= '0;
			cnt_q   <= '0;
			seq_q   <= 1'b0;
			conn_q  <= 1'b0;
			hack_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			ptr_q   <= ptr_d;
			cnt_q   <= cnt_d;
			seq_q   <= seq_d;
			conn_q  <= conn_d;
			hack_q  <= hack_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		ptr_d   = ptr_q;
		cnt_d   = cnt_q;
		seq_d   = seq_q;
		conn_d  = conn_q;
		hack_d  = hack_q;
		wr      = '0;
		wr.addr = ptr_q;
		res     = '0;
		res.outcome = OUT_PENDING;
		if (acc) begin
			case (phase_q)
				PH_IDLE: begin
					if (item.operation == OP_SEND) begin
						ptr_d  = (ptr_q == PTR_W'(WINDOW_SIZE - 1)) ? '0 : ptr_q + PTR_W'(1);
						hack_d = !conn_q;
						res.transmit       = 1'b1;
						res.frame_seq      = seq_q;
						res.frame_ack_flag = !conn_q;
						phase_d = PH_FIRST;
					end else begin
						res.outcome = OUT_ORDER_ERR;
					end
				end
				PH_FIRST: begin
					if (item.operation == OP_SEND) begin
						res.outcome = OUT_ORDER_ERR;
					end else if (valid_ack) begin
						conn_d = 1'b1;
						if (match) begin
							wr.en       = 1'b1;
							wr.data     = 1'b0;
							cnt_d       = cnt_clr;
							res.outcome = OUT_ACKED;
						end else begin
							res.outcome = OUT_LOSS_OK;
						end
						seq_d        = !seq_q;
						phase_d      = PH_IDLE;
						res.done_res = 1'b1;
					end else begin
						wr.en   = 1'b1;
						wr.data = 1'b1;
						cnt_d   = cnt_lost;
						if (over_tol) begin
							phase_d = PH_RETRY;
						end else begin
							seq_d        = !seq_q;
							phase_d      = PH_IDLE;
							res.done_res = 1'b1;
							res.outcome  = OUT_LOSS_OK;
						end
					end
				end
				PH_RETRY: begin
					if (item.operation == OP_SEND) begin
						res.outcome = OUT_ORDER_ERR;
					end else if (valid_ack && match) begin
						wr.en        = 1'b1;
						wr.data      = 1'b0;
						cnt_d        = cnt_clr;
						seq_d        = !seq_q;
						phase_d      = PH_IDLE;
						res.done_res = 1'b1;
						res.outcome  = OUT_ACKED;
					end else begin
						res.transmit       = 1'b1;
						res.frame_seq      = seq_q;
						res.frame_ack_flag = hack_q;
					end
				end
				default: begin
					res.outcome = OUT_ORDER_ERR;
				end
			endcase
		end
		if (32'(cnt_d) > 32'(LOSS_SAT)) begin
			res.losses_in_window = LOSS_W'(LOSS_SAT);
		end else begin
			res.losses_in_window = LOSS_W'(cnt_d);
		end
	end

	// output register plus skid
	assign item.ready = !s_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
			s_vld_q <= 1'b0;
		end else begin
			if (!o_vld_q || result.ready) begin
				o_vld_q <= s_vld_q || acc;
				s_vld_q <= 1'b0;
			end else if (acc) begin
				s_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!o_vld_q || result.ready) begin
			o_q <= s_vld_q ? s_q : res;
		end else if (acc) begin
			s_q <= res;
		end
	end

	assign result.valid            = o_vld_q;
	assign result.transmit         = o_q.transmit;
	assign result.frame_seq        = o_q.frame_seq;
	assign result.frame_ack_flag   = o_q.frame_ack_flag;
	assign result.done_res         = o_q.done_res;
	assign result.outcome          = o_q.outcome;
	assign result.losses_in_window = o_q.losses_in_window;

endmodule

/* rtl/core/prsw_check.sv */
// Port-level assertions for the stop-and-wait sender, bound to the top level.
module prsw_check (
	input logic         clk,
	input logic         arst_n,
	prsw_out_if.source  result
);
	import prsw_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.outcome)
			&& $stable(result.losses_in_window))
		else $error("result beat changed while stalled");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.outcome == OUT_ORDER_ERR |-> !result.transmit && !result.done_res)
		else $error("out-of-order beat sent a frame or finished");

	a_no_tx_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.transmit |-> !result.frame_seq && !result.frame_ack_flag)
		else $error("frame fields set without transmit");

	a_done_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.done_res |->
			result.outcome == OUT_ACKED || result.outcome == OUT_LOSS_OK)
		else $error("finished beat with bad outcome");

	a_loss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> 32'(result.losses_in_window) <= 32'(WINDOW_SIZE))
		else $error("loss count above window size");

endmodule

bind partial_reliability_stop_and_wait_tx prsw_check u_prsw_check (
	.clk    (clk),
	.arst_n (arst_n),
	.result (result)
);
